FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with arst_n as reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define KSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true outside reset
`define KSD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/ksd_pkg.sv
// ----------------------------------------------------------------------------
// ksd_pkg
// Constants, register indexes and helpers of the key sequence detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ksd_pkg;

	// Key space and sequence geometry
	localparam int NUM_KEYS      = 256;
	localparam int MAX_SEQ_LEN   = 8;
	localparam int NUM_SEQUENCES = 4;
	localparam int SEQ_SLOTS     = 4;
	localparam int HIST_DEPTH    = 8;
	localparam int KEY_W         = 8;
	localparam int LEN_W         = 4;
	localparam int POS_W         = 3;
	localparam int SEQ_KEYS_W    = KEY_W * MAX_SEQ_LEN;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_INDEX_W-1:0] REG_SEQ_ZERO  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEQ_ONE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SEQ_TWO   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SEQ_THREE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTHS   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ENABLES   = 3'd5;

	// Action codes
	localparam logic ACT_PRESS = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// Slot bit set for the newest history entry
	localparam logic [HIST_DEPTH-1:0] NEW_SLOT_BIT = 8'h01;

	typedef logic [KEY_W-1:0] key_t;

	// A key code has a tracking plane only below NUM_KEYS
	function automatic logic key_in_range(input key_t k);
		key_in_range = ({1'b0, k} < (KEY_W+1)'(NUM_KEYS));
	endfunction

	// Length nibble saturated to the longest sequence
	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] nib);
		sat_len = (nib > LEN_W'(MAX_SEQ_LEN)) ? LEN_W'(MAX_SEQ_LEN) : nib;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/key_sequence_detector.sv
// A transaction is accepted into the input register; history update and compare then move
// it into the result register once that register is free or being drained.
// Throughput: one item per cycle while out_ready drains the result register; the single
// compare stage of 8-bit byte comparators per sequence sets the pace.
// Reset: clears configuration, the key history valid bits and all valid flags;
// the stored key codes are left as they are.
// ----------------------------------------------------------------------------
// key_sequence_detector
// Shifts a history of recent key presses and reports which configured key
// sequences match the newest keys, one match mask per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module key_sequence_detector
	import ksd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write channel
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   action,
	input  wire logic [KEY_W-1:0]       key_code,
	// result channel
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [SEQ_SLOTS-1:0]        match_mask
);

	// Configuration registers
	logic [SEQ_KEYS_W-1:0]      seq_keys_q [SEQ_SLOTS];
	logic [LEN_W*SEQ_SLOTS-1:0] seq_lengths_q;
	logic [SEQ_SLOTS-1:0]       seq_enables_q;

	// Input stage
	logic valid_s1;
	logic action_s1;
	key_t key_s1;

	// History and result
	key_t                  hist_keys_q [HIST_DEPTH];
	logic [HIST_DEPTH-1:0] hist_valid_q;
	logic                  out_valid_q;
	logic [SEQ_SLOTS-1:0]  match_mask_q;

	logic                  advance;
	logic                  cfg_wr;
	key_t                  hist_keys_nxt [HIST_DEPTH];
	logic [HIST_DEPTH-1:0] hist_valid_nxt;
	logic [SEQ_SLOTS-1:0]  match_nxt;
	logic                  flush_s1;
	logic                  press_s1;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// Stage 1 moves on when the result register is free or being drained
	assign advance  = ~out_valid_q | out_ready;
	assign in_ready = ~valid_s1 | advance;

	assign out_valid  = out_valid_q;
	assign match_mask = match_mask_q;

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SEQ_SLOTS; s++) begin
				seq_keys_q[s] <= '0;
			end
			seq_lengths_q <= '0;
			seq_enables_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_SEQ_ZERO:  seq_keys_q[0] <= cfg_data[SEQ_KEYS_W-1:0];
				REG_SEQ_ONE:   seq_keys_q[1] <= cfg_data[SEQ_KEYS_W-1:0];
				REG_SEQ_TWO:   seq_keys_q[2] <= cfg_data[SEQ_KEYS_W-1:0];
				REG_SEQ_THREE: seq_keys_q[3] <= cfg_data[SEQ_KEYS_W-1:0];
				REG_LENGTHS:   seq_lengths_q <= cfg_data[LEN_W*SEQ_SLOTS-1:0];
				REG_ENABLES:   seq_enables_q <= cfg_data[SEQ_SLOTS-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			key_s1    <= key_code;
		end
	end

	// Next history: a press shifts in the new key, a flush invalidates all
	always_comb begin
		hist_keys_nxt[0] = key_s1;
		for (int j = 1; j < HIST_DEPTH; j++) begin
			hist_keys_nxt[j] = hist_keys_q[j-1];
		end
		if (action_s1 == ACT_FLUSH) begin
			hist_valid_nxt = '0;
		end else begin
			hist_valid_nxt = {hist_valid_q[HIST_DEPTH-2:0], 1'b0};
			if (key_in_range(key_s1)) begin
				hist_valid_nxt = hist_valid_nxt | NEW_SLOT_BIT;
			end
		end
	end

	// Compare every sequence against the newest keys, last entry vs newest key
	always_comb begin
		logic [LEN_W-1:0] len;
		logic [POS_W-1:0] pos;
		key_t             want;
		logic             hit;
		match_nxt = '0;
		for (int s = 0; s < SEQ_SLOTS; s++) begin
			len = sat_len(seq_lengths_q[LEN_W*s +: LEN_W]);
			hit = seq_enables_q[s] && (s < NUM_SEQUENCES);
			for (int j = 0; j < HIST_DEPTH; j++) begin
				pos  = POS_W'(len - LEN_W'(j) - LEN_W'(1));
				want = seq_keys_q[s][{pos, 3'b000} +: KEY_W];
				if (LEN_W'(j) < len) begin
					if (!hist_valid_nxt[j] || !key_in_range(want) ||
					    hist_keys_nxt[j] != want) begin
						hit = 1'b0;
					end
				end
			end
			if (action_s1 == ACT_PRESS) begin
				match_nxt[s] = hit;
			end
		end
	end

	// History and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q <= '0;
			out_valid_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				hist_valid_q <= hist_valid_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			match_mask_q <= match_nxt;
			if (action_s1 == ACT_PRESS) begin
				hist_keys_q <= hist_keys_nxt;
			end
		end
	end

	// Stage 1 transaction moving into the result register
	assign flush_s1 = advance & valid_s1 & (action_s1 == ACT_FLUSH);
	assign press_s1 = advance & valid_s1 & (action_s1 == ACT_PRESS);

	// Assertions
	`KSD_ASSERT(a_flush_zero, flush_s1 |=> match_mask_q == '0 && hist_valid_q == '0,
		"flush must clear history and give an empty mask")
	`KSD_ASSERT(a_press_shift,
		press_s1 |=> hist_valid_q[HIST_DEPTH-1:1] == $past(hist_valid_q[HIST_DEPTH-2:0]),
		"press must shift the history valid bits")
	`KSD_ASSERT(a_press_newest, press_s1 |=> hist_valid_q[0] == $past(key_in_range(key_s1)),
		"newest slot valid must follow the key range")
	`KSD_ASSERT_NEVER(a_stall_no_take, out_valid_q && !out_ready && valid_s1 && in_ready,
		"input taken while both stages are stalled")

endmodule

`default_nettype wire
